FILE: hw/rtl/qdd_pkg.sv
package qdd_pkg;

   localparam int PHASE_W  = 2;
   localparam int ROT_W    = 2;
   localparam int STEPS_W  = 4;
   localparam int HOLD_W   = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [STEPS_W-1:0] STEPS_RESET = 4'd4;
   localparam logic [HOLD_W-1:0]  HOLD_RESET  = 8'd50;
   // pulse fires at threshold, counting stops at threshold + 5,
   // lockout parks the count at threshold + 10, capped at 255
   localparam logic [HOLD_W:0]    HOLD_MARGIN  = 9'd5;
   localparam logic [HOLD_W:0]    HOLD_LOCKOUT = 9'd10;
   localparam logic [HOLD_W-1:0]  HOLD_MAX     = 8'd255;

   typedef enum logic [ROT_W-1:0] {
      ROT_NONE = 2'd0,
      ROT_UP   = 2'd1,
      ROT_DOWN = 2'd2
   } rot_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEPS_PER_DETENT = 1'd0,
      CSR_HOLD_THRESHOLD   = 1'd1
   } csr_idx_type;

   typedef struct packed {
      logic [STEPS_W-1:0] steps_per_detent;
      logic [HOLD_W-1:0]  hold_threshold;
   } cfg_type;

   // Gray-code transition: up 0->2->3->1->0, down 0->1->3->2->0
   function automatic rot_type step_kind(input logic [PHASE_W-1:0] prev,
                                         input logic [PHASE_W-1:0] next);
      rot_type kind;
      case ({prev, next})
         4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: kind = ROT_UP;
         4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: kind = ROT_DOWN;
         default:                                kind = ROT_NONE;
      endcase
      return kind;
   endfunction

endpackage

FILE: hw/rtl/qdd_req_if.sv
interface qdd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] phase_pair;
   logic       button_level;

   modport source (output valid, output phase_pair, output button_level, input ready);
   modport sink   (input valid, input phase_pair, input button_level, output ready);
endinterface

FILE: hw/rtl/qdd_rsp_if.sv
interface qdd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] rotation;
   logic       press_pulse;

   modport source (output valid, output rotation, output press_pulse, input ready);
   modport sink   (input valid, input rotation, input press_pulse, output ready);
endinterface

FILE: hw/rtl/quadrature_detent_decoder_top.sv
// channel   dir  payload                                   handshake
// req_chan  in   phase_pair[1:0], button_level             valid/ready
// rsp_chan  out  rotation[1:0], press_pulse                valid/ready
// csr_*     in   csr_index[0], csr_wdata[7:0]              csr_we, no back-pressure
//
// One sample per cycle sustained while results are taken; a request beat passes
// through the input register, then the counter update into the result register.
// Reset is synchronous: counters, last phase and both valid flags clear,
// settings return to 4 steps per detent and a hold threshold of 50.
// A stalled result holds both stages; the input stage still takes a beat
// whenever it is empty.
module quadrature_detent_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   qdd_req_if.sink                           req_chan,
   qdd_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [qdd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qdd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   qdd_pkg::cfg_type            cfg_ff, cfg_in;
   logic                        in_valid_ff, in_valid_in;
   logic [qdd_pkg::PHASE_W-1:0] in_phase_ff;
   logic                        in_button_ff;
   logic                        out_valid_ff, out_valid_in;
   qdd_pkg::rot_type            out_rot_ff, rot;
   logic                        out_pulse_ff, pulse;
   logic                        advance;
   logic                        step;
   logic                        req_beat;

   // settings
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (qdd_pkg::csr_idx_type'(csr_index))
            qdd_pkg::CSR_STEPS_PER_DETENT:
               cfg_in.steps_per_detent = csr_wdata[qdd_pkg::STEPS_W-1:0];
            qdd_pkg::CSR_HOLD_THRESHOLD:
               cfg_in.hold_threshold = csr_wdata[qdd_pkg::HOLD_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_detent <= qdd_pkg::STEPS_RESET;
         cfg_ff.hold_threshold   <= qdd_pkg::HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_beat       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_phase_ff  <= req_chan.phase_pair;
         in_button_ff <= req_chan.button_level;
      end
      if (step) begin
         out_rot_ff   <= rot;
         out_pulse_ff <= pulse;
      end
   end

   qdd_rotary u_rotary (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .phase            (in_phase_ff),
      .steps_per_detent (cfg_ff.steps_per_detent),
      .rotation         (rot)
   );

   qdd_button u_button (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .button_level   (in_button_ff),
      .hold_threshold (cfg_ff.hold_threshold),
      .press_pulse    (pulse)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.rotation    = out_rot_ff;
   assign rsp_chan.press_pulse = out_pulse_ff;

   a_rot_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_rot_ff == qdd_pkg::ROT_NONE || out_rot_ff == qdd_pkg::ROT_UP ||
                        out_rot_ff == qdd_pkg::ROT_DOWN))
      else $error("rotation code out of range");

   a_step_fills_out: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("stepped sample did not reach result register");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held sample dropped from input register");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

FILE: hw/rtl/qdd_rotary.sv
module qdd_rotary (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [qdd_pkg::PHASE_W-1:0]   phase,
   input  logic [qdd_pkg::STEPS_W-1:0]   steps_per_detent,
   output qdd_pkg::rot_type              rotation
);

   logic [qdd_pkg::PHASE_W-1:0] last_phase_ff, last_phase_in;
   logic [qdd_pkg::STEPS_W-1:0] up_steps_ff, up_steps_in;
   logic [qdd_pkg::STEPS_W-1:0] down_steps_ff, down_steps_in;
   qdd_pkg::rot_type            kind;
   logic [qdd_pkg::STEPS_W-1:0] up_next, down_next;

   always_comb begin
      kind          = qdd_pkg::step_kind(last_phase_ff, phase);
      up_next       = up_steps_ff;
      down_next     = down_steps_ff;
      rotation      = qdd_pkg::ROT_NONE;
      last_phase_in = last_phase_ff;
      up_steps_in   = up_steps_ff;
      down_steps_in = down_steps_ff;
      if (phase != last_phase_ff) begin
         if (kind == qdd_pkg::ROT_UP) begin
            up_next = up_steps_ff + 1'b1;
         end else if (kind == qdd_pkg::ROT_DOWN) begin
            down_next = down_steps_ff + 1'b1;
         end
         // down wins when both have reached the setting
         if (down_next >= steps_per_detent) begin
            rotation = qdd_pkg::ROT_DOWN;
         end else if (up_next >= steps_per_detent) begin
            rotation = qdd_pkg::ROT_UP;
         end
         last_phase_in = phase;
         if (rotation != qdd_pkg::ROT_NONE) begin
            up_steps_in   = '0;
            down_steps_in = '0;
         end else begin
            up_steps_in   = up_next;
            down_steps_in = down_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= '0;
         up_steps_ff   <= '0;
         down_steps_ff <= '0;
      end else if (step) begin
         last_phase_ff <= last_phase_in;
         up_steps_ff   <= up_steps_in;
         down_steps_ff <= down_steps_in;
      end
   end

endmodule

FILE: hw/rtl/qdd_button.sv
module qdd_button (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         button_level,
   input  logic [qdd_pkg::HOLD_W-1:0]   hold_threshold,
   output logic                         press_pulse
);

   logic [qdd_pkg::HOLD_W-1:0] hold_count_ff, hold_count_in;
   logic [qdd_pkg::HOLD_W:0]   lock_sum;
   logic [qdd_pkg::HOLD_W:0]   limit_sum;

   always_comb begin
      lock_sum      = {1'b0, hold_threshold} + qdd_pkg::HOLD_LOCKOUT;
      limit_sum     = {1'b0, hold_threshold} + qdd_pkg::HOLD_MARGIN;
      press_pulse   = 1'b0;
      hold_count_in = hold_count_ff;
      if (button_level) begin
         hold_count_in = '0;
      end else if (hold_count_ff == hold_threshold) begin
         // fire once, then park above the threshold until release (a threshold of 255 parks at 255, so it fires again)
         press_pulse   = 1'b1;
         hold_count_in = lock_sum[qdd_pkg::HOLD_W] ? qdd_pkg::HOLD_MAX
                                                   : lock_sum[qdd_pkg::HOLD_W-1:0];
      end else if ({1'b0, hold_count_ff} < limit_sum) begin
         hold_count_in = hold_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= '0;
      end else if (step) begin
         hold_count_ff <= hold_count_in;
      end
   end

endmodule

FILE: sim/quadrature_detent_decoder_top_test.sv
`timescale 1ns / 100ps

module quadrature_detent_decoder_top_test;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int NUM_PHASES  = 9;
   localparam int DIRECTED_N  = 24;
   // {phase_pair, button_level}, first beat in the top bits
   localparam logic [3*DIRECTED_N-1:0] DIRECTED_SAMPLES = {
      3'b001, 3'b101, 3'b111, 3'b010, 3'b000, 3'b010, 3'b110, 3'b110,
      3'b000, 3'b111, 3'b101, 3'b111, 3'b101, 3'b000, 3'b011, 3'b100,
      3'b100, 3'b100, 3'b100, 3'b011, 3'b010, 3'b000, 3'b100, 3'b111
   };

   // next phase code for one legal step in each direction
   localparam logic [1:0] UP_NEXT   [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   localparam logic [1:0] DOWN_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

   localparam int STEPS_PLAN [NUM_PHASES] = '{2, 4, 15, 1, 0, 15, 3, 0, 0};
   localparam int THR_PLAN   [NUM_PHASES] = '{2, 50, 0, 240, 255, 7, 1, 0, 0};
   localparam int ITEMS_PLAN [NUM_PHASES] = '{0, 250, 200, 300, 300, 200, 150, 150, 180};

   typedef struct packed {
      logic [qdd_pkg::PHASE_W-1:0] phase;
      logic                        button;
   } encoder_sample_type;

   typedef struct packed {
      qdd_pkg::rot_type rotation;
      logic             press_pulse;
   } detent_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   qdd_pkg::csr_idx_type csr_index = qdd_pkg::CSR_STEPS_PER_DETENT;
   logic [qdd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   qdd_req_if req_bus ();
   qdd_rsp_if rsp_bus ();

   quadrature_detent_decoder_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   encoder_sample_type pending_samples [$];
   detent_event_type   expected_events [$];

   // decoder state as predicted
   logic [qdd_pkg::STEPS_W-1:0] pred_steps_per_detent;
   logic [qdd_pkg::HOLD_W-1:0]  pred_hold_threshold;
   logic [qdd_pkg::PHASE_W-1:0] pred_last_phase;
   logic [qdd_pkg::STEPS_W-1:0] pred_up_steps;
   logic [qdd_pkg::STEPS_W-1:0] pred_down_steps;
   logic [qdd_pkg::HOLD_W-1:0]  pred_hold_count;

   int send_idle_pct = 21;
   int recv_idle_pct = 54;
   int samples_sent = 0;
   int events_checked = 0;
   int rotations_seen = 0;
   int pulses_seen = 0;
   int error_count = 0;
   int cycle_count = 0;
   bit hold_for_drain = 1'b0;
   encoder_sample_type next_sample;
   detent_event_type   oldest_event;

   // random stimulus generator state
   logic [qdd_pkg::PHASE_W-1:0] gen_phase = '0;
   bit gen_up = 1'b1;
   int press_left = 0;
   int release_left = 0;

   function automatic detent_event_type advance_decoder(input encoder_sample_type s);
      detent_event_type ev;
      logic [qdd_pkg::HOLD_W:0] lockout;
      ev.rotation = qdd_pkg::ROT_NONE;
      ev.press_pulse = 1'b0;
      if (s.phase != pred_last_phase) begin
         if (s.phase == UP_NEXT[pred_last_phase])
            pred_up_steps = pred_up_steps + 1'b1;
         else if (s.phase == DOWN_NEXT[pred_last_phase])
            pred_down_steps = pred_down_steps + 1'b1;
         pred_last_phase = s.phase;
         if (pred_up_steps >= pred_steps_per_detent)
            ev.rotation = qdd_pkg::ROT_UP;
         // down takes priority when both counts have reached the setting
         if (pred_down_steps >= pred_steps_per_detent)
            ev.rotation = qdd_pkg::ROT_DOWN;
         if (ev.rotation != qdd_pkg::ROT_NONE) begin
            pred_up_steps = '0;
            pred_down_steps = '0;
         end
      end
      if (!s.button) begin
         if (pred_hold_count == pred_hold_threshold) begin
            lockout = {1'b0, pred_hold_threshold} + qdd_pkg::HOLD_LOCKOUT;
            pred_hold_count = (lockout > qdd_pkg::HOLD_MAX) ? qdd_pkg::HOLD_MAX
                                                            : lockout[qdd_pkg::HOLD_W-1:0];
            ev.press_pulse = 1'b1;
         end else if ({1'b0, pred_hold_count} <
                      {1'b0, pred_hold_threshold} + qdd_pkg::HOLD_MARGIN) begin
            pred_hold_count = pred_hold_count + 1'b1;
         end
      end else begin
         pred_hold_count = '0;
      end
      return ev;
   endfunction

   // sender: predict on each accepted beat, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         pred_steps_per_detent = qdd_pkg::STEPS_RESET;
         pred_hold_threshold = qdd_pkg::HOLD_RESET;
         pred_last_phase = '0;
         pred_up_steps = '0;
         pred_down_steps = '0;
         pred_hold_count = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               qdd_pkg::CSR_STEPS_PER_DETENT:
                  pred_steps_per_detent = csr_wdata[qdd_pkg::STEPS_W-1:0];
               qdd_pkg::CSR_HOLD_THRESHOLD:
                  pred_hold_threshold = csr_wdata[qdd_pkg::HOLD_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            next_sample.phase = req_bus.phase_pair;
            next_sample.button = req_bus.button_level;
            expected_events.push_back(advance_decoder(next_sample));
            samples_sent++;
            if (samples_sent % 211 == 100)
               hold_for_drain = 1'b1;
         end
         if (hold_for_drain && expected_events.size() == 0)
            hold_for_drain = 1'b0;
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_samples.size() != 0 && !hold_for_drain &&
                $urandom_range(99) >= send_idle_pct) begin
               next_sample = pending_samples.pop_front();
               req_bus.phase_pair <= next_sample.phase;
               req_bus.button_level <= next_sample.button;
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each result beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected result beat: rotation %0d, press_pulse %0d",
                      rsp_bus.rotation, rsp_bus.press_pulse);
               error_count++;
            end else begin
               oldest_event = expected_events.pop_front();
               events_checked++;
               if (rsp_bus.rotation !== oldest_event.rotation) begin
                  $error("rotation: expected %0d, got %0d",
                         oldest_event.rotation, rsp_bus.rotation);
                  error_count++;
               end else if (oldest_event.rotation != qdd_pkg::ROT_NONE) begin
                  rotations_seen++;
               end
               if (rsp_bus.press_pulse !== oldest_event.press_pulse) begin
                  $error("press_pulse: expected %0d, got %0d",
                         oldest_event.press_pulse, rsp_bus.press_pulse);
                  error_count++;
               end else if (oldest_event.press_pulse) begin
                  pulses_seen++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("quadrature_detent_decoder_top: mismatch");
         $finish;
      end
   end

   task automatic write_setting(input qdd_pkg::csr_idx_type idx, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[qdd_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_bus.valid || expected_events.size() != 0)
         @(posedge clock);
      // let the two pipeline stages settle
      repeat (4) @(posedge clock);
   endtask

   task automatic load_directed();
      encoder_sample_type s;
      for (int i = 0; i < DIRECTED_N; i++) begin
         s = DIRECTED_SAMPLES[3*(DIRECTED_N-1-i) +: 3];
         pending_samples.push_back(s);
      end
   endtask

   // mostly well-formed rotation with long button holds; some jitter and jumps
   task automatic load_random(input int count, input int thr);
      encoder_sample_type s;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if ($urandom_range(99) < 8)
            gen_up = !gen_up;
         if (pick < 70)
            gen_phase = gen_up ? UP_NEXT[gen_phase] : DOWN_NEXT[gen_phase];
         else if (pick < 85)
            gen_phase = gen_phase;
         else if (pick < 92)
            gen_phase = gen_up ? DOWN_NEXT[gen_phase] : UP_NEXT[gen_phase];
         else
            gen_phase = 2'($urandom_range(3));
         s.phase = gen_phase;
         if (press_left == 0 && release_left == 0) begin
            pick = $urandom_range(9);
            if (pick < 6)
               press_left = $urandom_range(thr + 14);
            else if (pick < 8)
               press_left = thr + 1;
            else
               press_left = $urandom_range(4);
            release_left = $urandom_range(6, 1);
         end
         if (press_left > 0) begin
            s.button = 1'b0;
            press_left--;
         end else begin
            s.button = 1'b1;
            release_left--;
         end
         // contact bounce
         if ($urandom_range(99) < 4)
            s.button = 1'($urandom_range(1));
         pending_samples.push_back(s);
      end
   endtask

   initial begin
      int steps;
      int thr;
      req_bus.valid = 1'b0;
      req_bus.phase_pair = '0;
      req_bus.button_level = 1'b1;
      rsp_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         steps = STEPS_PLAN[ph];
         thr = THR_PLAN[ph];
         if (ph >= 7) begin
            steps = $urandom_range(15);
            thr = $urandom_range(30);
         end
         write_setting(qdd_pkg::CSR_STEPS_PER_DETENT, steps);
         write_setting(qdd_pkg::CSR_HOLD_THRESHOLD, thr);
         if (ph < 4) begin
            send_idle_pct = 21;
            recv_idle_pct = 54;
         end else if (ph < 7) begin
            send_idle_pct = 54;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 0)
            load_directed();
         else
            load_random(ITEMS_PLAN[ph], thr);
      end
      wait_idle();
      repeat (8) @(posedge clock);
      $display("checked %0d samples over %0d detent/threshold settings",
               events_checked, NUM_PHASES);
      $display("saw %0d rotation steps and %0d press pulses", rotations_seen, pulses_seen);
      if (error_count == 0) begin
         $display("quadrature_detent_decoder_top: match");
      end else begin
         $display("quadrature_detent_decoder_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/qdd_pkg.sv
hw/rtl/qdd_req_if.sv
hw/rtl/qdd_rsp_if.sv
hw/rtl/qdd_rotary.sv
hw/rtl/qdd_button.sv
hw/rtl/quadrature_detent_decoder_top.sv
sim/quadrature_detent_decoder_top_test.sv
